/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

/* design/bcdf_pkg.sv */
// ----------------------------------------------------------------------------
// Block common divisor filter package
// Field widths, default parameter values and status codes.
// ----------------------------------------------------------------------------
package bcdf_pkg;

    localparam int FIELD_BITS       = 32;
    localparam int STATUS_BITS      = 2;
    localparam int DEF_BLOCK_DEPTH  = 64;
    localparam int DEF_VALUE_BITS   = 32;

    localparam logic [FIELD_BITS-1:0] MAX_VALUE_RESET = 32'hFFFF_FFFF;

    localparam logic [STATUS_BITS-1:0] ST_APPLIED     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_APPLIED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE_ERROR = 2'd2;

endpackage

/* design/bcdf_store.sv */
// ----------------------------------------------------------------------------
// Value store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module bcdf_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/bcdf_divider.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcdf_divider #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, div_reg};
        if (!diff[WIDTH]) begin
            rem_next = diff[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], 1'b1};
        end else begin
            rem_next = rem_shift[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* design/block_common_divisor_filter_unit.sv */
// ----------------------------------------------------------------------------
// Block common divisor filter
// Collects a block of values, tracks their greatest common divisor and
// emits the block divided by that divisor when it is in range.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  cfg      in         cfg_wr_en           cfg_wr_data (max_value)
//  s        in         s_valid / s_ready   s_value, s_last_value
//  m        out        m_valid / m_ready   m_quotient, m_common_divisor,
//                                          m_new_max_value, m_status,
//                                          m_last_result
//
// Each input transfer runs its Euclid remainder steps on the one shared
// serial divider. At block close the maximum is divided only when applied,
// then each result is divided when applied and passed through otherwise.
// Reset is synchronous; the store needs no clearing pass.
// A stalled result holds the emit sequence; a new block is accepted while
// the final result of the previous block still waits.
// ----------------------------------------------------------------------------
module block_common_divisor_filter_unit
    import bcdf_pkg::*;
#(
    parameter int BLOCK_DEPTH = DEF_BLOCK_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [FIELD_BITS-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FIELD_BITS-1:0]  s_value,
    input  logic                   s_last_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_BITS-1:0]  m_quotient,
    output logic [FIELD_BITS-1:0]  m_common_divisor,
    output logic [FIELD_BITS-1:0]  m_new_max_value,
    output logic [STATUS_BITS-1:0] m_status,
    output logic                   m_last_result
);

    localparam int W  = VALUE_BITS;
    localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int CW = $clog2(BLOCK_DEPTH + 1);

    localparam logic [3:0] S_IN       = 4'd0;
    localparam logic [3:0] S_GCD      = 4'd1;
    localparam logic [3:0] S_GCD_WAIT = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_MAX_WAIT = 4'd4;
    localparam logic [3:0] S_FETCH    = 4'd5;
    localparam logic [3:0] S_DATA     = 4'd6;
    localparam logic [3:0] S_QUO_WAIT = 4'd7;
    localparam logic [3:0] S_PUSH     = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          k_reg;
    logic                   close_reg;
    logic [W-1:0]           gx_reg, gy_reg;
    logic [W-1:0]           g_reg;
    logic [FIELD_BITS-1:0]  max_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [W-1:0]           newmax_reg;
    logic [W-1:0]           q_reg;

    logic                   m_valid_reg;
    logic [FIELD_BITS-1:0]  m_quotient_reg;
    logic [FIELD_BITS-1:0]  m_divisor_reg;
    logic [FIELD_BITS-1:0]  m_new_max_reg;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic                   m_last_reg;

    logic                   in_xfer;
    logic [W-1:0]           v_in;
    logic [W-1:0]           max_w;
    logic                   applied;
    logic                   out_free;
    logic                   is_final;

    logic                   div_start;
    logic [W-1:0]           div_dividend;
    logic [W-1:0]           div_divisor;
    logic                   div_done;
    logic [W-1:0]           div_quo;
    logic [W-1:0]           div_rem;

    logic                   rd_en;
    logic [W-1:0]           rd_data;

    assign s_ready  = (state_reg == S_IN);
    assign in_xfer  = s_valid && s_ready;
    assign v_in     = W'(s_value);
    assign max_w    = W'(max_reg);
    assign applied  = (status_reg == ST_APPLIED);
    assign out_free = !m_valid_reg || m_ready;
    assign is_final = (CW'(k_reg + 1'b1) == count_reg);
    assign rd_en    = (state_reg == S_FETCH);

    bcdf_store #(
        .DEPTH (BLOCK_DEPTH),
        .WIDTH (W),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_xfer),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (v_in),
        .rd_en   (rd_en),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // The divider serves the Euclid steps, the maximum and the quotients of an applied block.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = gy_reg;
        div_divisor  = gx_reg;
        unique case (state_reg)
            S_GCD: begin
                div_start = (gx_reg != '0);
            end
            S_DECIDE: begin
                div_start    = (g_reg > W'(1)) && (g_reg <= max_w);
                div_dividend = max_w;
                div_divisor  = g_reg;
            end
            S_DATA: begin
                div_start    = applied;
                div_dividend = rd_data;
                div_divisor  = g_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bcdf_divider #(
        .WIDTH (W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IN: begin
                if (in_xfer) begin
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (gx_reg != '0) begin
                    state_next = S_GCD_WAIT;
                end else if (close_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_IN;
                end
            end
            S_GCD_WAIT: begin
                if (div_done) begin
                    state_next = S_GCD;
                end
            end
            S_DECIDE: begin
                state_next = div_start ? S_MAX_WAIT : S_FETCH;
            end
            S_MAX_WAIT: begin
                if (div_done) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_DATA;
            end
            S_DATA: begin
                state_next = applied ? S_QUO_WAIT : S_PUSH;
            end
            S_QUO_WAIT: begin
                if (div_done) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    state_next = is_final ? S_IN : S_FETCH;
                end
            end
            default: begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IN;
            count_reg   <= '0;
            g_reg       <= '0;
            max_reg     <= MAX_VALUE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            if (in_xfer) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_GCD && gx_reg == '0) begin
                g_reg <= gy_reg;
            end
            if (state_reg == S_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
                if (is_final) begin
                    count_reg <= '0;
                    g_reg     <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            close_reg <= s_last_value || (count_reg == CW'(BLOCK_DEPTH - 1));
            // Euclid starts with the smaller operand as the divisor.
            if (g_reg > v_in) begin
                gx_reg <= v_in;
                gy_reg <= g_reg;
            end else begin
                gx_reg <= g_reg;
                gy_reg <= v_in;
            end
        end
        if (state_reg == S_GCD_WAIT && div_done) begin
            gy_reg <= gx_reg;
            gx_reg <= div_rem;
        end
        if (state_reg == S_DECIDE) begin
            k_reg      <= '0;
            newmax_reg <= max_w;
            if (g_reg <= W'(1)) begin
                status_reg <= ST_NOT_APPLIED;
            end else if (g_reg > max_w) begin
                status_reg <= ST_RANGE_ERROR;
            end else begin
                status_reg <= ST_APPLIED;
            end
        end
        if (state_reg == S_MAX_WAIT && div_done) begin
            newmax_reg <= div_quo;
        end
        if (state_reg == S_DATA) begin
            q_reg <= rd_data;
        end
        if (state_reg == S_QUO_WAIT && div_done) begin
            q_reg <= div_quo;
        end
        if (state_reg == S_PUSH && out_free) begin
            m_quotient_reg <= FIELD_BITS'(q_reg);
            m_divisor_reg  <= FIELD_BITS'(g_reg);
            m_new_max_reg  <= FIELD_BITS'(newmax_reg);
            m_status_reg   <= status_reg;
            m_last_reg     <= is_final;
            k_reg          <= k_reg + 1'b1;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_quotient       = m_quotient_reg;
    assign m_common_divisor = m_divisor_reg;
    assign m_new_max_value  = m_new_max_reg;
    assign m_status         = m_status_reg;
    assign m_last_result    = m_last_reg;

endmodule

/* design/bcdf_checker.sv */
// ----------------------------------------------------------------------------
// Block common divisor filter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcdf_checker
    import bcdf_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [FIELD_BITS-1:0]  m_quotient,
    input logic [FIELD_BITS-1:0]  m_common_divisor,
    input logic [FIELD_BITS-1:0]  m_new_max_value,
    input logic [STATUS_BITS-1:0] m_status,
    input logic                   m_last_result
);

    // A result that waits must keep its contents.
    `ASSERT_CLK_RST(a_hold_stalled, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_quotient)
            && $stable(m_common_divisor) && $stable(m_new_max_value)
            && $stable(m_status) && $stable(m_last_result),
        "stalled result changed")

    // Division happens only with a divisor above one.
    `ASSERT_CLK_RST(a_applied_div, aclk, aresetn,
        m_valid && (m_status == ST_APPLIED) |-> (m_common_divisor > 32'd1),
        "applied with divisor at most one")

    // Not applied is reported only with a trivial divisor.
    `ASSERT_CLK_RST(a_trivial_div, aclk, aresetn,
        m_valid && (m_status == ST_NOT_APPLIED) |-> (m_common_divisor <= 32'd1),
        "not applied with divisor above one")

    // Reset empties the result register.
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind block_common_divisor_filter_unit bcdf_checker u_bcdf_checker (.*);

/* verif/block_common_divisor_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// Block common divisor filter testbench
// Sends blocks of values through the filter, predicts the greatest common
// divisor, status and divided outputs of each block, and compares every
// result transfer field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module block_common_divisor_filter_unit_tb
    import bcdf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_DEPTH      = DEF_BLOCK_DEPTH;
    localparam int SETTLE_CYCLES    = 2 * (DEF_VALUE_BITS + 5) + 30;
    localparam int ITEMS_PER_PHASE  = 16;

    typedef struct {
        logic [FIELD_BITS-1:0]  quotient;
        logic [FIELD_BITS-1:0]  common_divisor;
        logic [FIELD_BITS-1:0]  new_max_value;
        logic [STATUS_BITS-1:0] status;
        logic                   last_result;
    } filter_result_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [FIELD_BITS-1:0]  cfg_wr_data  = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [FIELD_BITS-1:0]  s_value      = '0;
    logic                   s_last_value = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [FIELD_BITS-1:0]  m_quotient;
    logic [FIELD_BITS-1:0]  m_common_divisor;
    logic [FIELD_BITS-1:0]  m_new_max_value;
    logic [STATUS_BITS-1:0] m_status;
    logic                   m_last_result;

    // Predictor state: the open block, its running divisor and the register.
    logic [FIELD_BITS-1:0]  open_block[$];
    logic [FIELD_BITS-1:0]  block_divisor  = '0;
    logic [FIELD_BITS-1:0]  max_value_copy = MAX_VALUE_RESET;
    filter_result_t         pending_results[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    block_common_divisor_filter_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .s_last_value     (s_last_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quotient       (m_quotient),
        .m_common_divisor (m_common_divisor),
        .m_new_max_value  (m_new_max_value),
        .m_status         (m_status),
        .m_last_result    (m_last_result)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [FIELD_BITS-1:0] euclid_gcd(input logic [FIELD_BITS-1:0] a,
                                                          input logic [FIELD_BITS-1:0] b);
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] t;
        x = (a > b) ? b : a;
        y = (a > b) ? a : b;
        while (x != 0) begin
            t = x;
            x = y % x;
            y = t;
        end
        return y;
    endfunction

    // Stores one accepted value and, when the block closes, queues its results.
    function automatic void predict_block_results(input logic [FIELD_BITS-1:0] value,
                                                  input logic last_value);
        filter_result_t        res;
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  new_max;
        open_block.push_back(value);
        block_divisor = euclid_gcd(block_divisor, value);
        if (last_value || open_block.size() == BLOCK_DEPTH) begin
            new_max = max_value_copy;
            if (block_divisor <= 1) begin
                status = ST_NOT_APPLIED;
            end else if (block_divisor > max_value_copy) begin
                status = ST_RANGE_ERROR;
            end else begin
                status  = ST_APPLIED;
                new_max = max_value_copy / block_divisor;
            end
            foreach (open_block[k]) begin
                res.quotient       = (status == ST_APPLIED) ? open_block[k] / block_divisor
                                                            : open_block[k];
                res.common_divisor = block_divisor;
                res.new_max_value  = new_max;
                res.status         = status;
                res.last_result    = (k == open_block.size() - 1);
                pending_results.push_back(res);
            end
            open_block.delete();
            block_divisor = '0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [FIELD_BITS-1:0] exp_val,
                                          input logic [FIELD_BITS-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    function automatic void check_result_transfer();
        filter_result_t exp_res;
        if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual quotient %0h",
                     $time, m_quotient);
            error_count++;
        end else begin
            exp_res = pending_results.pop_front();
            compare_field("quotient", exp_res.quotient, m_quotient);
            compare_field("common_divisor", exp_res.common_divisor, m_common_divisor);
            compare_field("new_max_value", exp_res.new_max_value, m_new_max_value);
            compare_field("status", FIELD_BITS'(exp_res.status), FIELD_BITS'(m_status));
            compare_field("last_result", FIELD_BITS'(exp_res.last_result),
                          FIELD_BITS'(m_last_result));
        end
    endfunction

    // Both handshakes are sampled at the clock edge, before any update of that edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_block_results(s_value, s_last_value);
            end
            if (m_valid && m_ready) begin
                check_result_transfer();
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid is only lowered in idle cycles, so back-to-back transfers keep it high.
    task automatic send_item(input logic [FIELD_BITS-1:0] value, input logic last_value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value      <= value;
        s_last_value <= last_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_value(input logic [FIELD_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        max_value_copy = value;
    endtask

    // Sends one block ending with the last flag and returns its length.
    task automatic send_random_block(output int sent);
        int                    kind;
        int                    len;
        logic [FIELD_BITS-1:0] divisor;
        logic [FIELD_BITS-1:0] limit;
        logic [FIELD_BITS-1:0] value;
        kind = $urandom_range(9);
        len  = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
        case ($urandom_range(3))
            0: divisor = $urandom_range(16, 2);
            1: divisor = 32'd1 << $urandom_range(31, 1);
            2: divisor = $urandom_range(65535, 2);
            default: divisor = $urandom;
        endcase
        if (kind == 8) begin
            // Divisor right at or just past the configured maximum.
            divisor = (max_value_copy == '1) ? max_value_copy
                                             : max_value_copy + $urandom_range(1);
        end
        if (divisor == 0) divisor = 1;
        limit = 32'hFFFF_FFFF / divisor;
        for (int i = 0; i < len; i++) begin
            if (kind == 9 || (kind == 7 && $urandom_range(2) != 0)) begin
                value = '0;
            end else if (kind == 5 || kind == 6) begin
                value = $urandom;
            end else if ($urandom_range(7) == 0) begin
                value = divisor * limit;
            end else begin
                value = divisor * $urandom_range(limit);
            end
            send_item(value, i == len - 1);
        end
        sent = len;
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [FIELD_BITS-1:0] max_setting);
        int total;
        int sent;
        int blocks;
        wait_results_drained();
        write_max_value(max_setting);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        total  = 0;
        blocks = 0;
        while (total < ITEMS_PER_PHASE) begin
            send_random_block(sent);
            total += sent;
            blocks++;
            if (blocks == 1 || $urandom_range(7) == 0) wait_results_drained();
        end
    endtask

    task automatic test_reset_max_value();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(32'd0, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'd12, 1'b0);
        send_item(32'd18, 1'b0);
        send_item(32'd30, 1'b1);
        // A block of zeros leaves the divisor at zero.
        send_item(32'd0, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd0, 1'b1);
        send_item(32'd7, 1'b0);
        send_item(32'd11, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(32'd10, 1'b1);
        send_item(32'd1, 1'b1);
    endtask

    task automatic test_max_value_limits();
        wait_results_drained();
        write_max_value(32'd100);
        send_item(32'd200, 1'b0);
        send_item(32'd400, 1'b1);
        send_item(32'd100, 1'b0);
        send_item(32'd300, 1'b1);
        wait_results_drained();
        write_max_value(32'd0);
        send_item(32'd0, 1'b1);
        send_item(32'd2, 1'b0);
        send_item(32'd4, 1'b1);
    endtask

    // The 64th value closes the block even without the last flag.
    task automatic test_full_store();
        wait_results_drained();
        write_max_value($urandom);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        for (int i = 0; i < BLOCK_DEPTH; i++) begin
            send_item(32'd3 * $urandom_range(32'h5555_5555), 1'b0);
        end
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b1);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_max_value();
        test_max_value_limits();
        run_random_phase(0, 0, 32'hFFFF_FFFF);
        run_random_phase(84, 0, $urandom);
        run_random_phase(0, 84, $urandom_range(1000, 1));
        run_random_phase(14, 14, 32'd0);
        test_full_store();
        wait_results_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
